// ===== hw/rtl/segment_circle_obstacle_test_top_assert.svh =====
// Assertion macros used by the top-level RTL. Define ASSERT_OFF to compile them out.
`ifndef SEGMENT_CIRCLE_OBSTACLE_TEST_TOP_ASSERT_SVH
`define SEGMENT_CIRCLE_OBSTACLE_TEST_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, quiet during reset
`define SOCT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define SOCT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define SOCT_ASSERT_IMP(lbl, ante, cons)
`define SOCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/soct_pkg.sv =====
package soct_pkg;

    // Field widths
    localparam int COORD_W   = 14;
    localparam int RAD_W     = 12;
    localparam int AGENT_W   = 12;
    localparam int COUNT_W   = 5;
    localparam int INDEX_W   = 4;
    localparam int DIFF_W    = COORD_W + 1;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_AGENT_RADIUS   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBSTACLE_COUNT = 1'd1;

    localparam logic [AGENT_W-1:0] AGENT_RADIUS_RST   = 12'd128;
    localparam logic [COUNT_W-1:0] OBSTACLE_COUNT_RST = 5'd0;

    localparam int MAX_OBSTACLES_DEF = 16;

    // Commands
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [COORD_W-1:0] centre_x;
        logic [COORD_W-1:0] centre_z;
        logic [RAD_W-1:0]   obstacle_radius;
        logic [COORD_W-1:0] seg_start_x;
        logic [COORD_W-1:0] seg_start_z;
        logic [COORD_W-1:0] seg_end_x;
        logic [COORD_W-1:0] seg_end_z;
    } item_t;

    typedef struct packed {
        logic collides;
    } result_t;

    // One obstacle table entry
    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cz;
        logic [RAD_W-1:0]   rad;
    } entry_t;

    // Segment held for the whole query
    typedef struct packed {
        logic [COORD_W-1:0]       sx;
        logic [COORD_W-1:0]       sz;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
    } query_t;

    // Control tag that travels beside an entry through the intersection unit
    typedef struct packed {
        logic vld;
        logic check;
        logic last;
    } tag_t;

    // Per-entry verdict from the intersection unit
    typedef struct packed {
        logic vld;
        logic last;
        logic hit;
    } res_t;

endpackage

// ===== hw/rtl/soct_if.sv =====
interface soct_item_if;
    import soct_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface soct_result_if;
    import soct_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/segment_circle_obstacle_test_top.sv =====
// Segment versus circular obstacle test. A load transaction (cmd 0) writes one
// obstacle entry and returns nothing; a query transaction (cmd 1) returns one
// collides flag. The obstacle table is a row of cells, one per entry; a query
// copies every entry into the row, which then shifts one entry per cycle into a
// shared six-stage intersection unit. A query with n = min(obstacle_count,
// MAX_OBSTACLES) issues its n entries, or one unchecked entry when n is 0, and
// its result passes the six unit stages into the output register. The next
// transaction is taken once that result has left the working path, even while
// it still waits in the output register; loads are accepted every cycle while
// idle, but no transaction is taken while a query is still in the working path.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Entries never loaded must not be queried.
module segment_circle_obstacle_test_top #(
    parameter int MAX_OBSTACLES = soct_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    soct_item_if.sink                        item,
    soct_result_if.source                    result,
    input  logic                             cfg_we,
    input  logic [soct_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [soct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import soct_pkg::*;

    localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

    typedef enum logic [1:0] {IDLE, ISSUE, DRAIN, HOLD} state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic               acc_reg, acc_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    logic               collides_reg, collides_next;
    logic [AGENT_W-1:0] agent_radius_reg;
    logic [COUNT_W-1:0] obstacle_count_reg;
    query_t             query_reg;

    logic               item_acc;
    logic               query_acc;
    logic               load_acc;
    logic               out_free;
    logic               acc_upd;
    logic [CNT_W-1:0]   n_sat;
    tag_t               issue_tag;
    res_t               unit_res;
    entry_t             load_entry;
    entry_t             travel [MAX_OBSTACLES];

    assign item_acc  = item.valid && item.ready;
    assign query_acc = item_acc && (item.data.cmd == CMD_QUERY);
    assign load_acc  = item_acc && (item.data.cmd == CMD_LOAD);
    assign out_free  = !out_valid_reg || result.ready;
    assign acc_upd   = acc_reg || (unit_res.vld && unit_res.hit);
    assign n_sat     = (32'(obstacle_count_reg) > MAX_OBSTACLES) ?
                       CNT_W'(MAX_OBSTACLES) : CNT_W'(obstacle_count_reg);

    assign load_entry.cx  = item.data.centre_x;
    assign load_entry.cz  = item.data.centre_z;
    assign load_entry.rad = item.data.obstacle_radius;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agent_radius_reg   <= AGENT_RADIUS_RST;
            obstacle_count_reg <= OBSTACLE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AGENT_RADIUS:   agent_radius_reg   <= cfg_data[AGENT_W-1:0];
                CFG_OBSTACLE_COUNT: obstacle_count_reg <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Hold the segment for the whole query
    always_ff @(posedge clk)
    begin
        if (query_acc)
        begin
            query_reg.sx <= item.data.seg_start_x;
            query_reg.sz <= item.data.seg_start_z;
            query_reg.dx <= $signed({1'b0, item.data.seg_end_x}) -
                            $signed({1'b0, item.data.seg_start_x});
            query_reg.dz <= $signed({1'b0, item.data.seg_end_z}) -
                            $signed({1'b0, item.data.seg_start_z});
        end
    end

    // Sequencer: issue entries, gather verdicts, hand over the result
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !result.ready;
        collides_next  = collides_reg;
        issue_tag      = '0;

        if (unit_res.vld)
        begin
            acc_next = acc_upd;
        end

        case (state_reg)
            IDLE:
            begin
                if (query_acc)
                begin
                    n_next     = n_sat;
                    idx_next   = '0;
                    acc_next   = 1'b0;
                    state_next = ISSUE;
                end
            end
            ISSUE:
            begin
                issue_tag.vld   = 1'b1;
                issue_tag.check = (n_reg != '0);
                issue_tag.last  = (n_reg == '0) || (CNT_W'(idx_reg + 1'b1) == n_reg);
                idx_next        = idx_reg + 1'b1;
                if (issue_tag.last)
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                if (unit_res.vld && unit_res.last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        collides_next  = acc_upd;
                        state_next     = IDLE;
                    end
                    else
                    begin
                        pend_next  = acc_upd;
                        state_next = HOLD;
                    end
                end
            end
            HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    collides_next  = pend_reg;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            acc_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            collides_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            collides_reg  <= collides_next;
        end
    end

    // Row of table cells, shifting towards cell 0
    for (genvar k = 0; k < MAX_OBSTACLES; k++)
    begin : g_cell
        entry_t upstream;

        if (k == MAX_OBSTACLES - 1)
        begin : g_tail
            assign upstream = '0;
        end
        else
        begin : g_link
            assign upstream = travel[k+1];
        end

        soct_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk        (clk),
            .load_en    (load_acc),
            .load_index (item.data.entry_index),
            .load_entry (load_entry),
            .capture    (query_acc),
            .shift      (state_reg == ISSUE),
            .upstream   (upstream),
            .travel     (travel[k])
        );
    end

    soct_xunit u_xunit (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry        (travel[0]),
        .query        (query_reg),
        .agent_radius (agent_radius_reg),
        .tag_in       (issue_tag),
        .res          (unit_res)
    );

    assign item.ready           = (state_reg == IDLE);
    assign result.valid         = out_valid_reg;
    assign result.data.collides = collides_reg;

    `include "segment_circle_obstacle_test_top_assert.svh"

    `SOCT_ASSERT_IMP(a_res_in_query, unit_res.vld, (state_reg == ISSUE || state_reg == DRAIN))
    `SOCT_ASSERT_IMP(a_idx_range, state_reg == ISSUE, (n_reg == '0 || idx_reg < n_reg))
    `SOCT_ASSERT_IMP(a_hold_out_full, state_reg == HOLD, out_valid_reg)
    `SOCT_ASSERT_NEXT(a_hold_release, (state_reg == HOLD && result.ready), (state_reg == IDLE && out_valid_reg))

endmodule

// ===== hw/rtl/soct_cell.sv =====
module soct_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                          clk,
    input  logic                          load_en,
    input  logic [soct_pkg::INDEX_W-1:0]  load_index,
    input  soct_pkg::entry_t              load_entry,
    input  logic                          capture,
    input  logic                          shift,
    input  soct_pkg::entry_t              upstream,
    output soct_pkg::entry_t              travel
);
    import soct_pkg::*;

    entry_t entry_reg;
    entry_t travel_reg;
    logic   hit_slot;

    assign hit_slot = (32'(load_index) == CELL_IDX);

    // Store this slot's obstacle on a matching load
    always_ff @(posedge clk)
    begin
        if (load_en && hit_slot)
        begin
            entry_reg <= load_entry;
        end
    end

    // Take own entry at query start, then pass the neighbour's along
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            travel_reg <= entry_reg;
        end
        else if (shift)
        begin
            travel_reg <= upstream;
        end
    end

    assign travel = travel_reg;

endmodule

// ===== hw/rtl/soct_xunit.sv =====
module soct_xunit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  soct_pkg::entry_t              entry,
    input  soct_pkg::query_t              query,
    input  logic [soct_pkg::AGENT_W-1:0]  agent_radius,
    input  soct_pkg::tag_t                tag_in,
    output soct_pkg::res_t                res
);
    import soct_pkg::*;

    localparam int PIPE_DEPTH = 6;
    localparam int GROWN_W    = RAD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int EDGE_W     = SUM_W + 1;
    localparam int WIDE_W     = 64;

    tag_t tag_reg [PIPE_DEPTH];

    // Stage 1: offsets from the centre and grown radius
    logic signed [DIFF_W-1:0]  fx_reg, fx_next;
    logic signed [DIFF_W-1:0]  fz_reg, fz_next;
    logic [GROWN_W-1:0]        r_reg, r_next;
    // Stage 2: products
    logic signed [PROD_W-1:0]  pxx_reg, pxx_next;
    logic signed [PROD_W-1:0]  pzz_reg, pzz_next;
    logic signed [PROD_W-1:0]  pxd_reg, pxd_next;
    logic signed [PROD_W-1:0]  pzd_reg, pzd_next;
    logic signed [PROD_W-1:0]  pdx_reg, pdx_next;
    logic signed [PROD_W-1:0]  pdz_reg, pdz_next;
    logic [2*GROWN_W-1:0]      prr_reg, prr_next;
    // Stage 3: quadratic coefficients
    logic signed [SUM_W-1:0]   a_reg, a_next;
    logic signed [SUM_W-1:0]   h_reg, h_next;
    logic signed [SUM_W-1:0]   c_reg, c_next;
    // Stage 4: squares and root-bound edges
    logic signed [WIDE_W-1:0]  hh_reg, hh_next;
    logic signed [WIDE_W-1:0]  ac_reg, ac_next;
    logic signed [EDGE_W-1:0]  m_reg, m_next;
    logic signed [EDGE_W-1:0]  p_reg, p_next;
    logic                      hnp_reg, hnp_next;
    logic                      az_reg, az_next;
    // Stage 5: discriminant and squared edges
    logic signed [WIDE_W-1:0]  disc_reg, disc_next;
    logic signed [WIDE_W-1:0]  hh5_reg;
    logic signed [WIDE_W-1:0]  mm_reg, mm_next;
    logic signed [WIDE_W-1:0]  pp_reg, pp_next;
    logic                      hnp5_reg;
    logic                      az5_reg;
    logic                      mnp_reg, mnp_next;
    logic                      pnn_reg, pnn_next;
    // Stage 6: verdict
    logic                      hit_reg, hit_next;
    logic                      lo_ok, hi_ok;

    assign fx_next = $signed({1'b0, query.sx}) - $signed({1'b0, entry.cx});
    assign fz_next = $signed({1'b0, query.sz}) - $signed({1'b0, entry.cz});
    assign r_next  = {1'b0, entry.rad} + {1'b0, agent_radius};

    assign pxx_next = fx_reg * fx_reg;
    assign pzz_next = fz_reg * fz_reg;
    assign pxd_next = fx_reg * query.dx;
    assign pzd_next = fz_reg * query.dz;
    assign pdx_next = query.dx * query.dx;
    assign pdz_next = query.dz * query.dz;
    assign prr_next = r_reg * r_reg;

    assign a_next = SUM_W'(pdx_reg) + SUM_W'(pdz_reg);
    assign h_next = SUM_W'(pxd_reg) + SUM_W'(pzd_reg);
    assign c_next = SUM_W'(pxx_reg) + SUM_W'(pzz_reg) - $signed(SUM_W'(prr_reg));

    assign hh_next  = h_reg * h_reg;
    assign ac_next  = a_reg * c_reg;
    assign m_next   = -EDGE_W'(h_reg) - EDGE_W'(a_reg);
    assign p_next   = EDGE_W'(a_reg) + EDGE_W'(h_reg);
    assign hnp_next = (h_reg <= 0);
    assign az_next  = (a_reg == 0);

    assign disc_next = hh_reg - ac_reg;
    assign mm_next   = m_reg * m_reg;
    assign pp_next   = p_reg * p_reg;
    assign mnp_next  = (m_reg <= 0);
    assign pnn_next  = (p_reg >= 0);

    // Lower root in [0,1] and upper root in [0,1], squared-bound form
    assign lo_ok    = hnp5_reg && (disc_reg <= hh5_reg) && (mnp_reg || (disc_reg >= mm_reg));
    assign hi_ok    = pnn_reg && (disc_reg <= pp_reg) && (hnp5_reg || (disc_reg >= hh5_reg));
    assign hit_next = !az5_reg && (disc_reg >= 0) && (lo_ok || hi_ok);

    // Advance the data path
    always_ff @(posedge clk)
    begin
        fx_reg   <= fx_next;
        fz_reg   <= fz_next;
        r_reg    <= r_next;
        pxx_reg  <= pxx_next;
        pzz_reg  <= pzz_next;
        pxd_reg  <= pxd_next;
        pzd_reg  <= pzd_next;
        pdx_reg  <= pdx_next;
        pdz_reg  <= pdz_next;
        prr_reg  <= prr_next;
        a_reg    <= a_next;
        h_reg    <= h_next;
        c_reg    <= c_next;
        hh_reg   <= hh_next;
        ac_reg   <= ac_next;
        m_reg    <= m_next;
        p_reg    <= p_next;
        hnp_reg  <= hnp_next;
        az_reg   <= az_next;
        disc_reg <= disc_next;
        hh5_reg  <= hh_reg;
        mm_reg   <= mm_next;
        pp_reg   <= pp_next;
        hnp5_reg <= hnp_reg;
        az5_reg  <= az_reg;
        mnp_reg  <= mnp_next;
        pnn_reg  <= pnn_next;
        hit_reg  <= hit_next;
    end

    // Advance the control tags beside the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    assign res.vld  = tag_reg[PIPE_DEPTH-1].vld;
    assign res.last = tag_reg[PIPE_DEPTH-1].last;
    assign res.hit  = tag_reg[PIPE_DEPTH-1].check && hit_reg;

endmodule

// ===== test/segment_collision_checker.sv =====
module segment_collision_checker #(
    parameter int MAX_OBSTACLES = soct_pkg::MAX_OBSTACLES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    soct_item_if                            item_ch,
    soct_result_if                          result_ch,
    input  logic                            cfg_we,
    input  logic [soct_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [soct_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              awaited,
    output int                              fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import soct_pkg::*;

    // Shadow copy of the obstacle table and registers
    entry_t             obstacle_rows [MAX_OBSTACLES];
    logic [AGENT_W-1:0] agent_radius;
    logic [COUNT_W-1:0] obstacle_count;

    // Collides flags owed by the block, oldest first
    bit                 collide_expected [$];
    int                 mismatches;

    // Decide whether start + t*d, t in [0,1], meets the circle of radius r.
    // Work on squared quantities only, so the decision is exact.
    function automatic bit circle_crossed(longint fx, longint fz, longint dx,
                                          longint dz, longint r);
        longint a;
        longint h;
        longint c;
        longint disc;
        longint m;
        longint p;
        bit     lower_in;
        bit     upper_in;

        a = dx * dx + dz * dz;
        h = fx * dx + fz * dz;
        c = fx * fx + fz * fz - r * r;
        // A point segment never crosses
        if (a == 0)
            return 1'b0;
        disc = h * h - a * c;
        // No real root: the line misses the circle
        if (disc < 0)
            return 1'b0;

        // Lower root (-h - s)/a lies in [0,1]
        lower_in = 1'b0;
        if (h <= 0 && disc <= h * h)
        begin
            m = -h - a;
            if (m <= 0 || disc >= m * m)
                lower_in = 1'b1;
        end

        // Upper root (-h + s)/a lies in [0,1]
        p = a + h;
        upper_in = (p >= 0) && (disc <= p * p) && (h <= 0 || disc >= h * h);
        return lower_in || upper_in;
    endfunction

    // Walk the active obstacles, grown by the agent radius, until one is crossed
    function automatic bit query_collides(item_t it);
        longint sx;
        longint sz;
        longint dx;
        longint dz;
        longint fx;
        longint fz;
        longint r;
        int     n;
        bit     hit;

        sx = longint'(it.seg_start_x);
        sz = longint'(it.seg_start_z);
        dx = longint'(it.seg_end_x) - sx;
        dz = longint'(it.seg_end_z) - sz;
        n = (int'(obstacle_count) > MAX_OBSTACLES) ? MAX_OBSTACLES : int'(obstacle_count);
        hit = 1'b0;
        for (int k = 0; k < n && !hit; k++)
        begin
            fx = sx - longint'(obstacle_rows[k].cx);
            fz = sz - longint'(obstacle_rows[k].cz);
            r = longint'(obstacle_rows[k].rad) + longint'(agent_radius);
            hit = circle_crossed(fx, fz, dx, dz, r);
        end
        return hit;
    endfunction

    // Track register writes and transactions, predict and compare
    always @(posedge clk or negedge rst_n)
    begin
        bit exp_hit;

        if (!rst_n)
        begin
            foreach (obstacle_rows[k])
                obstacle_rows[k] = '0;
            agent_radius = AGENT_RADIUS_RST;
            obstacle_count = OBSTACLE_COUNT_RST;
            collide_expected.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_AGENT_RADIUS:   agent_radius = cfg_data[AGENT_W-1:0];
                    CFG_OBSTACLE_COUNT: obstacle_count = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end

            if (item_ch.valid && item_ch.ready)
            begin
                if (item_ch.data.cmd == CMD_LOAD)
                begin
                    if (int'(item_ch.data.entry_index) < MAX_OBSTACLES)
                    begin
                        obstacle_rows[item_ch.data.entry_index].cx  = item_ch.data.centre_x;
                        obstacle_rows[item_ch.data.entry_index].cz  = item_ch.data.centre_z;
                        obstacle_rows[item_ch.data.entry_index].rad =
                            item_ch.data.obstacle_radius;
                    end
                end
                else
                begin
                    collide_expected = {collide_expected, query_collides(item_ch.data)};
                end
            end

            if (result_ch.valid && result_ch.ready)
            begin
                if (collide_expected.size() == 0)
                begin
                    $error("collides: no query awaiting a result, actual %0b",
                           result_ch.data.collides);
                    mismatches++;
                end
                else
                begin
                    exp_hit = collide_expected[0];
                    collide_expected.delete(0);
                    if (result_ch.data.collides !== exp_hit)
                    begin
                        $error("collides: expected %0b, actual %0b",
                               exp_hit, result_ch.data.collides);
                        mismatches++;
                    end
                end
            end
        end

        // Publish after the edge so the stimulus side reads settled values
        awaited    <= collide_expected.size();
        fail_count <= mismatches;
    end

endmodule

// ===== test/tb_segment_circle_obstacle_test_top.sv =====
module tb_segment_circle_obstacle_test_top;
    timeunit 1ns;
    timeprecision 1ps;

    import soct_pkg::*;

    localparam int MAX_OBS       = MAX_OBSTACLES_DEF;
    localparam int COORD_MAX     = 16383;
    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_AT       = 760;
    localparam int HOLD_CYCLES   = 300;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    soct_item_if   item_ch ();
    soct_result_if result_ch ();

    int awaited;
    int fail_count;
    int accepted_items = 0;
    int cycle_count = 0;

    // What the stimulus knows of the table and settings in force
    entry_t placed [MAX_OBS];
    int     live_agent;
    int     live_count;

    segment_circle_obstacle_test_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    segment_collision_checker #(
        .MAX_OBSTACLES (MAX_OBS)
    ) u_collision_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_ch    (item_ch),
        .result_ch  (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .awaited    (awaited),
        .fail_count (fail_count)
    );

    always #5 clk = ~clk;

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_segment_circle_obstacle_test_top failed");
            $finish;
        end
    end

    // Pick a coordinate within spread of base, clamped to the field range
    function automatic logic [COORD_W-1:0] near(int base, int spread);
        int v;

        v = base - spread + int'($urandom_range(0, 2 * spread));
        if (v < 0)
            v = 0;
        else if (v > COORD_MAX)
            v = COORD_MAX;
        return v[COORD_W-1:0];
    endfunction

    // Offer one transaction, idling first at the current rate
    task automatic send_item(input item_t it);
        int idle_pct;

        idle_pct = (accepted_items < 320) ? 11 : (accepted_items < 640) ? 64 : 0;
        while (int'($urandom_range(0, 99)) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        accepted_items <= accepted_items + 1;
    endtask

    // Drop valid and wait until every owed result is back and the path is quiet
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; the count word carries random upper bits
    task automatic configure(input int agent, input int count);
        logic [CFG_DATA_W-1:0] word;

        word = CFG_DATA_W'($urandom);
        word[COUNT_W-1:0] = COUNT_W'(count);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_AGENT_RADIUS;
        cfg_data  <= CFG_DATA_W'(agent);
        @(posedge clk);
        cfg_index <= CFG_OBSTACLE_COUNT;
        cfg_data  <= word;
        @(posedge clk);
        cfg_we <= 1'b0;
        live_agent = agent;
        live_count = (count > MAX_OBS) ? MAX_OBS : count;
    endtask

    // Load one obstacle; segment fields carry noise
    task automatic load_slot(input int slot, input int cx, input int cz, input int rad);
        item_t it;

        it = item_t'({$urandom, $urandom, $urandom, $urandom});
        it.cmd             = CMD_LOAD;
        it.entry_index     = INDEX_W'(slot);
        it.centre_x        = COORD_W'(cx);
        it.centre_z        = COORD_W'(cz);
        it.obstacle_radius = RAD_W'(rad);
        placed[slot].cx  = it.centre_x;
        placed[slot].cz  = it.centre_z;
        placed[slot].rad = it.obstacle_radius;
        send_item(it);
    endtask

    // Query one segment; load fields carry noise
    task automatic query(input int sx, input int sz, input int ex, input int ez);
        item_t it;

        it = item_t'({$urandom, $urandom, $urandom, $urandom});
        it.cmd         = CMD_QUERY;
        it.seg_start_x = COORD_W'(sx);
        it.seg_start_z = COORD_W'(sz);
        it.seg_end_x   = COORD_W'(ex);
        it.seg_end_z   = COORD_W'(ez);
        send_item(it);
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the block
    initial
    begin
        int  idle_pct;
        bit  hold_done;

        hold_done = 1'b0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && accepted_items >= HOLD_AT)
            begin
                hold_done = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                idle_pct = (accepted_items < 320) ? 64 : (accepted_items < 640) ? 11 : 0;
                result_ch.ready <= (int'($urandom_range(0, 99)) >= idle_pct);
            end
        end
    end

    // Stimulus
    initial
    begin
        int random_items;
        int agent;
        int count;
        int batch;
        int pick;
        int k;
        int g;
        int sx;
        int sz;
        int ex;
        int ez;

        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_AGENT_RADIUS;
        cfg_data      <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        live_agent = int'(AGENT_RADIUS_RST);
        live_count = int'(OBSTACLE_COUNT_RST);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no obstacle active, then fill the first four slots, three of them at the extremes
        query(0, 0, COORD_MAX, COORD_MAX);
        load_slot(0, 8192, 8192, 256);
        load_slot(1, 0, 0, 0);
        load_slot(2, COORD_MAX, COORD_MAX, 4095);
        load_slot(3, 0, COORD_MAX, 1000);
        settle();

        // One obstacle, grown radius 384 around (8192, 8192)
        configure(128, 1);
        query(8576, 8192, 8576, 8192);          // point segment on the boundary
        query(0, 8192, COORD_MAX, 8192);        // straight through
        query(8182, 8192, 8202, 8192);          // wholly inside
        query(0, 0, COORD_MAX, 0);              // line misses the circle
        query(0, 8192, 8192, 8192);             // ends inside
        query(8192, 8192, COORD_MAX, 8192);     // starts inside, leaves
        query(0, 8576, COORD_MAX, 8576);        // tangent
        query(0, 8192, 7792, 8192);             // stops short
        settle();

        // Largest agent radius over four obstacles
        configure(4095, 4);
        query(COORD_MAX, 0, 0, COORD_MAX);
        query(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        query(4000, 4000, 12000, 5000);
        settle();

        // No growth: zero-radius circle at the origin
        configure(0, 2);
        query(0, 0, 0, 0);
        query(0, 0, 100, 0);
        settle();

        // Fill the whole table so any count can be checked
        random_items = 0;
        for (int s = MAX_OBS - 1; s >= 0; s--)
        begin
            load_slot(s, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, 1200));
            random_items++;
        end
        settle();

        // Random phases: new settings, then a batch of mostly queries
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       agent = 0;
                1:       agent = 4095;
                2:       agent = $urandom_range(0, 4095);
                default: agent = $urandom_range(0, 511);
            endcase
            count = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_OBS + 1, 31)
                                                : $urandom_range(0, MAX_OBS);
            configure(agent, count);

            batch = $urandom_range(20, 60);
            repeat (batch)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 18)
                begin
                    load_slot($urandom_range(0, MAX_OBS - 1), $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX),
                              ($urandom_range(0, 9) == 0) ? 4095 : $urandom_range(0, 1200));
                end
                else if (pick < 88 && live_count > 0)
                begin
                    // Aim at an active obstacle so that crossings and near misses abound
                    k = $urandom_range(0, live_count - 1);
                    g = 2 * (int'(placed[k].rad) + live_agent) + 32;
                    sx = near(int'(placed[k].cx), g);
                    sz = near(int'(placed[k].cz), g);
                    if (pick < 28)
                    begin
                        ex = sx;
                        ez = sz;
                    end
                    else if (pick < 40)
                    begin
                        ex = near(sx, 64);
                        ez = near(sz, 64);
                    end
                    else
                    begin
                        ex = near(int'(placed[k].cx), g);
                        ez = near(int'(placed[k].cz), g);
                    end
                    query(sx, sz, ex, ez);
                end
                else
                begin
                    query($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                          $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                end
                random_items++;
            end
            settle();
        end

        if (fail_count == 0)
            $display("tb_segment_circle_obstacle_test_top passed");
        else
            $display("tb_segment_circle_obstacle_test_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/soct_pkg.sv
hw/rtl/soct_if.sv
hw/rtl/soct_cell.sv
hw/rtl/soct_xunit.sv
hw/rtl/segment_circle_obstacle_test_top.sv
test/segment_collision_checker.sv
test/tb_segment_circle_obstacle_test_top.sv
